[src/bol_pkg.sv]
package bol_pkg;

   // Bank dimensions
   localparam int NUM_LISTS    = 10;
   localparam int MAX_CAPACITY = 16;

   // Field widths, fixed by the item formats
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 4;
   localparam int AMT_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 4;
   localparam int FILL_W   = 5;

   // Derived sizes
   localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int DEPTH  = NUM_LISTS * MAX_CAPACITY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_SW = 8;   // signed working width for capacity sums

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE    = 3'd0,
      CMD_APPEND    = 3'd1,
      CMD_REM_LAST  = 3'd2,
      CMD_REM_VALUE = 3'd3,
      CMD_READ      = 3'd4,
      CMD_RESIZE    = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 4'd0,
      ST_BAD_SLOT     = 4'd1,
      ST_EXISTS       = 4'd2,
      ST_BAD_SIZE     = 4'd3,
      ST_NO_ROOM      = 4'd4,
      ST_FULL         = 4'd5,
      ST_NO_LIST      = 4'd6,
      ST_EMPTY        = 4'd7,
      ST_NOT_FOUND    = 4'd8,
      ST_BAD_NEW_SIZE = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_READ,
      S_EMIT
   } state_type;

endpackage

[src/bol_if.sv]
interface bol_req_if;
   import bol_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [SLOT_W-1:0]        list_slot;
   logic signed [AMT_W-1:0]  amount;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, command, list_slot, amount, value, input ready);
   modport sink   (input valid, command, list_slot, amount, value, output ready);
endinterface

interface bol_rsp_if;
   import bol_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic                     has_value;
   logic signed [DATA_W-1:0] element_value;
   logic [FILL_W-1:0]        fill_count;
   logic                     last_result;

   modport source (output valid, status, has_value, element_value, fill_count,
                   last_result, input ready);
   modport sink   (input valid, status, has_value, element_value, fill_count,
                   last_result, output ready);
endinterface

[src/bol_ram.sv]
module bol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bank_of_bounded_lists_unit.sv]
// Bank of bounded lists of signed words.
//
// req_chan (sink): one command item per handshake (valid & ready): command,
//   list_slot, amount, value. A new item is taken only while the sequencer is
//   idle, i.e. after every result of the previous item has entered the
//   output register.
// rsp_chan (source): result items from a single output register. A read of a
//   non-empty list gives one item per filled word, last_result on the final
//   one; every other command gives exactly one item.
// Sequencing: a simple command goes from S_EXEC through S_EMIT, where its result
//   enters the output register. A read and a remove-by-value walk the list
//   one element store access per cycle (a read-out pauses while the receiver
//   stalls), so the list length sets how long they take.
// Element words sit in one synchronous RAM (registered read); list
//   presence, capacity and fill live in flops.
// Reset clears the sequencer, the output register and all list descriptors;
//   the element RAM is not cleared, since only filled words are ever read.
// When the receiver stalls, the output register holds its item and the
//   read-out pauses with its pending word held at the RAM output.
module bank_of_bounded_lists_unit
   import bol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bol_req_if.sink    req_chan,
   bol_rsp_if.source  rsp_chan
);

   localparam logic [SLOT_W-1:0]        NUM_LISTS_S = SLOT_W'(NUM_LISTS);
   localparam logic [FILL_W-1:0]        MAXC_F      = FILL_W'(MAX_CAPACITY);
   localparam logic signed [CAP_SW-1:0] MAXC_S      = CAP_SW'(MAX_CAPACITY);
   localparam logic [ADDR_W-1:0]        ROW_SPAN    = ADDR_W'(MAX_CAPACITY);

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   // latched command
   logic [CMD_W-1:0]         cmd_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [AMT_W-1:0]  amount_ff;
   logic [DATA_W-1:0]        value_ff;

   // list descriptors
   logic              present_ff [NUM_LISTS];
   logic [FILL_W-1:0] cap_ff     [NUM_LISTS];
   logic [FILL_W-1:0] fill_ff    [NUM_LISTS];

   // walk over a list
   logic [FILL_W-1:0] walk_fill_ff, walk_fill_in;
   logic [FILL_W-1:0] rd_pos_ff, rd_pos_in;
   logic [FILL_W-1:0] dpos_ff, dpos_in;
   logic              dv_ff, dv_in;

   // single result waiting for the output register
   status_type        res_status_ff, res_status_in;
   logic [FILL_W-1:0] res_fill_ff, res_fill_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic              rsp_has_ff, rsp_has_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic              rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------- decoding
   logic [LIST_W-1:0] idx;
   logic              slot_bad;
   logic              cur_present;
   logic [FILL_W-1:0] cur_cap, cur_fill;
   logic [ADDR_W-1:0] base;
   logic signed [CAP_SW-1:0] amt_ext, ncap;

   assign idx      = LIST_W'(slot_ff - SLOT_W'(1));
   assign slot_bad = (slot_ff == '0) || (slot_ff > NUM_LISTS_S) || (cmd_ff > CMD_RESIZE);
   assign cur_present = present_ff[idx];
   assign cur_cap     = cap_ff[idx];
   assign cur_fill    = fill_ff[idx];
   assign base        = ADDR_W'(idx) * ROW_SPAN;
   assign amt_ext     = CAP_SW'(amount_ff);
   assign ncap        = signed'({{(CAP_SW-FILL_W){1'b0}}, cur_cap}) + amt_ext;

   // Result of the immediate checks, evaluated in S_EXEC
   status_type        ex_status;
   logic [FILL_W-1:0] ex_fill;
   state_type         ex_next;
   logic              ex_meta_we;
   logic              ex_present;
   logic [FILL_W-1:0] ex_cap, ex_new_fill;
   logic              ex_append;

   always_comb begin
      ex_status   = ST_OK;
      ex_fill     = '0;
      ex_next     = S_EMIT;
      ex_meta_we  = 1'b0;
      ex_present  = cur_present;
      ex_cap      = cur_cap;
      ex_new_fill = cur_fill;
      ex_append   = 1'b0;
      priority if (slot_bad) begin
         ex_status = ST_BAD_SLOT;
      end else if (cmd_ff == CMD_CREATE) begin
         priority if (cur_present) begin
            ex_status = ST_EXISTS;
            ex_fill   = cur_fill;
         end else if (amt_ext < CAP_SW'(1)) begin
            ex_status = ST_BAD_SIZE;
         end else if (amt_ext > MAXC_S) begin
            ex_status = ST_NO_ROOM;
         end else begin
            ex_meta_we  = 1'b1;
            ex_present  = 1'b1;
            ex_cap      = FILL_W'(amount_ff);
            ex_new_fill = '0;
         end
      end else if (!cur_present) begin
         ex_status = ST_NO_LIST;
      end else begin
         unique case (cmd_ff)
            CMD_APPEND: begin
               if (cur_fill >= cur_cap || cur_fill >= MAXC_F) begin
                  ex_status = ST_FULL;
                  ex_fill   = cur_fill;
               end else begin
                  ex_append   = 1'b1;
                  ex_meta_we  = 1'b1;
                  ex_new_fill = cur_fill + FILL_W'(1);
                  ex_fill     = cur_fill + FILL_W'(1);
               end
            end
            CMD_REM_LAST: begin
               if (cur_fill == '0) begin
                  ex_status = ST_EMPTY;
               end else begin
                  ex_meta_we  = 1'b1;
                  ex_new_fill = cur_fill - FILL_W'(1);
                  ex_fill     = cur_fill - FILL_W'(1);
               end
            end
            CMD_REM_VALUE: begin
               if (cur_fill == '0) begin
                  ex_status = ST_EMPTY;
               end else begin
                  ex_next = S_SCAN;
               end
            end
            CMD_READ: begin
               if (cur_fill != '0) begin
                  ex_next = S_READ;
               end
            end
            CMD_RESIZE: begin
               ex_fill = cur_fill;
               priority if (ncap < CAP_SW'(1)) begin
                  ex_status = ST_BAD_NEW_SIZE;
               end else if (ncap > MAXC_S) begin
                  ex_status = ST_NO_ROOM;
               end else begin
                  ex_meta_we = 1'b1;
                  ex_cap     = FILL_W'(ncap);
                  if (cur_fill > FILL_W'(ncap)) begin
                     ex_new_fill = FILL_W'(ncap);
                     ex_fill     = FILL_W'(ncap);
                  end
               end
            end
            default: begin
               ex_status = ST_BAD_SLOT;
            end
         endcase
      end
   end

   // --------------------------------------------------------- list walking
   logic              accept;
   logic              out_free;
   logic              in_walk;
   logic              consume;
   logic              issue;
   logic              match;
   logic              scan_miss;
   logic              shift_done;
   logic              read_done;
   logic              is_last;
   logic [DATA_W-1:0] rd_data;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign in_walk  = (state_ff == S_SCAN) || (state_ff == S_SHIFT) || (state_ff == S_READ);
   // read-out words must wait for the output register, scan words never wait
   assign consume  = (state_ff == S_READ) ? (dv_ff && out_free) : dv_ff;
   assign issue    = in_walk && (rd_pos_ff < walk_fill_ff) && (!dv_ff || consume);
   assign is_last  = (dpos_ff == walk_fill_ff - FILL_W'(1));
   assign match    = (state_ff == S_SCAN) && dv_ff && (rd_data == value_ff);
   assign scan_miss  = (state_ff == S_SCAN) && dv_ff && !match && is_last;
   assign shift_done = (state_ff == S_SHIFT) && !dv_ff && (rd_pos_ff == walk_fill_ff);
   assign read_done  = (state_ff == S_READ) && !dv_ff && (rd_pos_ff == walk_fill_ff);

   // ----------------------------------------------------------- element RAM
   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;

   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = base + ADDR_W'(cur_fill);
      ram_wr_data = value_ff;
      if (state_ff == S_EXEC && ex_append) begin
         ram_we = 1'b1;
      end else if (state_ff == S_SHIFT && dv_ff) begin
         // later words move down by one
         ram_we      = 1'b1;
         ram_wr_addr = base + ADDR_W'(dpos_ff - FILL_W'(1));
         ram_wr_data = rd_data;
      end
   end

   assign ram_rd_addr = base + ADDR_W'(rd_pos_ff);

   bol_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   // ----------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) begin
                     state_in = S_EXEC;
                  end
         S_EXEC:  state_in = ex_next;
         S_SCAN:  priority if (match) begin
                     state_in = S_SHIFT;
                  end else if (scan_miss) begin
                     state_in = S_EMIT;
                  end
         S_SHIFT: if (shift_done) begin
                     state_in = S_EMIT;
                  end
         S_READ:  if (read_done) begin
                     state_in = S_IDLE;
                  end
         S_EMIT:  if (out_free) begin
                     state_in = S_IDLE;
                  end
         default: state_in = S_IDLE;
      endcase
   end

   // -------------------------------------------------------------- outputs
   always_comb begin
      walk_fill_in  = walk_fill_ff;
      rd_pos_in     = rd_pos_ff;
      dpos_in       = dpos_ff;
      dv_in         = dv_ff;
      res_status_in = res_status_ff;
      res_fill_in   = res_fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;

      if (issue) begin
         rd_pos_in = rd_pos_ff + FILL_W'(1);
         dpos_in   = rd_pos_ff;
         dv_in     = 1'b1;
      end else if (consume) begin
         dv_in = 1'b0;
      end

      unique case (state_ff)
         S_EXEC: begin
            walk_fill_in  = cur_fill;
            rd_pos_in     = '0;
            dv_in         = 1'b0;
            res_status_in = ex_status;
            res_fill_in   = ex_fill;
         end
         S_SCAN: begin
            if (scan_miss) begin
               res_status_in = ST_NOT_FOUND;
               res_fill_in   = walk_fill_ff;
            end
         end
         S_SHIFT: begin
            if (shift_done) begin
               res_status_in = ST_OK;
               res_fill_in   = walk_fill_ff - FILL_W'(1);
            end
         end
         S_READ: begin
            if (consume) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_has_in    = 1'b1;
               rsp_value_in  = rd_data;
               rsp_fill_in   = walk_fill_ff;
               rsp_last_in   = is_last;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_has_in    = 1'b0;
               rsp_value_in  = '0;
               rsp_fill_in   = res_fill_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_chan.command;
         slot_ff   <= req_chan.list_slot;
         amount_ff <= req_chan.amount;
         value_ff  <= req_chan.value;
      end
      walk_fill_ff  <= walk_fill_in;
      rd_pos_ff     <= rd_pos_in;
      dpos_ff       <= dpos_in;
      res_status_ff <= res_status_in;
      res_fill_ff   <= res_fill_in;
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // descriptors: written by the immediate commands and at the end of a shift
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            present_ff[i] <= 1'b0;
            cap_ff[i]     <= '0;
            fill_ff[i]    <= '0;
         end
      end else if (state_ff == S_EXEC && ex_meta_we) begin
         present_ff[idx] <= ex_present;
         cap_ff[idx]     <= ex_cap;
         fill_ff[idx]    <= ex_new_fill;
      end else if (shift_done) begin
         fill_ff[idx] <= walk_fill_ff - FILL_W'(1);
      end
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.has_value     = rsp_has_ff;
   assign rsp_chan.element_value = $signed(rsp_value_ff);
   assign rsp_chan.fill_count    = rsp_fill_ff;
   assign rsp_chan.last_result   = rsp_last_ff;

   // ----------------------------------------------------------- assertions
   a_no_write_in_read: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !ram_we
   ) else $error("element store written during read-out");

   a_data_only_in_walk: assert property (
      @(posedge clock) disable iff (reset)
      dv_ff |-> in_walk
   ) else $error("RAM data pending outside a list walk");

   a_fill_within_cap: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !slot_bad && cur_present) |-> (cur_fill <= cur_cap)
   ) else $error("list fill above its capacity");

   a_accept_then_exec: assert property (
      @(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC)
   ) else $error("accepted item not decoded");

endmodule
